[rtl/i2cmps_pkg.sv]
// Shared command codes, widths and result type for the I2C master phase sequencer.
package i2cmps_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 5;
  localparam int unsigned SubW   = 2;

  // operation field codes; the idle command shares the tick code
  localparam logic [OpW-1:0] OP_TICK  = 3'd0;
  localparam logic [OpW-1:0] OP_START = 3'd1;
  localparam logic [OpW-1:0] OP_STOP  = 3'd2;
  localparam logic [OpW-1:0] OP_WRITE = 3'd3;
  localparam logic [OpW-1:0] OP_READ  = 3'd4;
  localparam logic [OpW-1:0] CMD_IDLE = OP_TICK;

  localparam logic [PhaseW-1:0] PH_LAST_SHORT = 5'd3;   // last phase of start and stop
  localparam logic [PhaseW-1:0] PH_WR_ACK     = 5'd24;  // write: ack sample phase
  localparam logic [PhaseW-1:0] PH_RD_ACK     = 5'd16;  // read: drive ACK or NACK
  localparam logic [PhaseW-1:0] PH_RD_SCL_HI  = 5'd17;
  localparam logic [PhaseW-1:0] PH_RD_SCL_LO  = 5'd18;

  localparam logic [SubW-1:0] SUB_DATA = 2'd0;
  localparam logic [SubW-1:0] SUB_HIGH = 2'd1;
  localparam logic [SubW-1:0] SUB_LOW  = 2'd2;

  // register indexes of the configuration port
  localparam logic [0:0] REG_ENABLED = 1'b0;

  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] read_data;
    logic             acked;
    logic             error;
  } result_t;

endpackage

[rtl/i2c_master_phase_sequencer.sv]
// Top level of the I2C master phase sequencer: command decode, phase logic and result register.

// An I2C master that moves one pin phase per item. A start, stop, write or read command is
// taken while enabled and idle and only loads the sequence; every later tick item performs
// one phase of SCL/SDA and samples sda_in where the master reads the line. Start and stop
// take 4 ticks, a write 26, a read 20. The state and the result register are updated
// in the cycle the item is accepted, and a new item is taken every cycle while the result
// register is empty or being drained. A command while disabled or busy reports error
// and changes nothing. Register 0 (byte address 0) holds enabled.
module i2c_master_phase_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [i2cmps_pkg::OpW-1:0]     operation_i,
  input  logic [i2cmps_pkg::ByteW-1:0]   data_byte_i,
  input  logic                           send_ack_i,
  input  logic                           sda_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           scl_out_o,
  output logic                           sda_out_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [i2cmps_pkg::ByteW-1:0]   read_data_o,
  output logic                           acked_o,
  output logic                           error_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import i2cmps_pkg::*;

  logic              enabled_q;
  logic [OpW-1:0]    cmd_q, cmd_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [SubW-1:0]   sub_q, sub_d;
  logic [ByteW-1:0]  shift_q, shift_d;
  logic              ack_choice_q, ack_choice_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              ack_flag_q, ack_flag_d;
  logic              out_valid_q;
  result_t           res_q, res_d;
  logic              accept;
  logic              cfg_wr;
  logic              is_cmd;
  logic              last;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_ENABLED);
  assign prdata     = (paddr[2] == REG_ENABLED) ? {31'd0, enabled_q} : 32'd0;
  assign is_cmd     = operation_i inside {[OP_START:OP_READ]};

  always_comb begin
    cmd_d        = cmd_q;
    phase_d      = phase_q;
    sub_d        = sub_q;
    shift_d      = shift_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    ack_flag_d   = ack_flag_q;
    last         = 1'b0;
    res_d        = '0;

    if (is_cmd) begin
      if (!enabled_q || cmd_q != CMD_IDLE) begin
        res_d.error = 1'b1;
      end else begin
        cmd_d        = operation_i;
        phase_d      = '0;
        sub_d        = SUB_DATA;
        ack_flag_d   = 1'b0;
        ack_choice_d = send_ack_i;
        shift_d      = (operation_i == OP_WRITE) ? data_byte_i : '0;
      end
    end else if (cmd_q != CMD_IDLE) begin
      case (cmd_q)
        OP_START: begin
          case (phase_q)
            5'd0:    sda_d = 1'b1;
            5'd1:    scl_d = 1'b1;
            5'd2:    sda_d = 1'b0;
            default: begin
              scl_d = 1'b0;
              last  = 1'b1;
            end
          endcase
        end
        OP_STOP: begin
          case (phase_q)
            5'd0:    scl_d = 1'b0;
            5'd1:    sda_d = 1'b0;
            5'd2:    scl_d = 1'b1;
            default: begin
              sda_d = 1'b1;
              last  = 1'b1;
            end
          endcase
        end
        OP_WRITE: begin
          if (phase_q < PH_WR_ACK) begin
            // data, SCL high, SCL low for each bit
            case (sub_q)
              SUB_DATA: begin
                sda_d   = shift_q[ByteW-1];
                shift_d = {shift_q[ByteW-2:0], 1'b0};
              end
              SUB_HIGH: scl_d = 1'b1;
              default:  scl_d = 1'b0;
            endcase
            sub_d = (sub_q == SUB_LOW) ? SUB_DATA : sub_q + 1'b1;
          end else if (phase_q == PH_WR_ACK) begin
            sda_d      = 1'b1;
            scl_d      = 1'b1;
            ack_flag_d = !sda_in_i;
          end else begin
            scl_d = 1'b0;
            last  = 1'b1;
          end
        end
        OP_READ: begin
          if (phase_q < PH_RD_ACK) begin
            if (!phase_q[0]) begin
              sda_d   = 1'b1;
              scl_d   = 1'b1;
              shift_d = {shift_q[ByteW-2:0], sda_in_i};
            end else begin
              scl_d = 1'b0;
            end
          end else if (phase_q == PH_RD_ACK) begin
            sda_d = !ack_choice_q;
          end else if (phase_q == PH_RD_SCL_HI) begin
            scl_d = 1'b1;
          end else if (phase_q == PH_RD_SCL_LO) begin
            scl_d = 1'b0;
          end else begin
            sda_d = 1'b1;
            last  = 1'b1;
          end
        end
        default: begin
          cmd_d   = CMD_IDLE;
          phase_d = '0;
        end
      endcase

      if (cmd_q inside {[OP_START:OP_READ]}) begin
        phase_d = phase_q + 1'b1;
      end
      if (last) begin
        cmd_d   = CMD_IDLE;
        phase_d = '0;
      end
      res_d.done      = last;
      res_d.read_data = (last && cmd_q == OP_READ) ? shift_d : '0;
      res_d.acked     = last && (cmd_q == OP_WRITE) && ack_flag_d;
    end

    res_d.scl  = scl_d;
    res_d.sda  = sda_d;
    res_d.busy = (cmd_d != CMD_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b0;
      cmd_q        <= CMD_IDLE;
      phase_q      <= '0;
      sub_q        <= SUB_DATA;
      shift_q      <= '0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      ack_flag_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        enabled_q <= pwdata[0];
      end
      if (accept) begin
        cmd_q        <= cmd_d;
        phase_q      <= phase_d;
        sub_q        <= sub_d;
        shift_q      <= shift_d;
        ack_choice_q <= ack_choice_d;
        scl_q        <= scl_d;
        sda_q        <= sda_d;
        ack_flag_q   <= ack_flag_d;
        out_valid_q  <= 1'b1;
      end else begin
        if (out_ready_i) begin
          out_valid_q <= 1'b0;
        end
        // SCL idles high once the bus is enabled
        if (cfg_wr && pwdata[0] && cmd_q == CMD_IDLE) begin
          scl_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = res_q.scl;
  assign sda_out_o   = res_q.sda;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign read_data_o = res_q.read_data;
  assign acked_o     = res_q.acked;
  assign error_o     = res_q.error;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(done_res_o && busy_res_o))
    else $error("done item still reports busy");

  a_error_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> !done_res_o && acked_o == 1'b0 && read_data_o == '0)
    else $error("rejected command also completes a phase");

  a_short_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q == OP_START || cmd_q == OP_STOP) |-> phase_q <= PH_LAST_SHORT)
    else $error("start or stop phase counter overran");

  a_error_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_cmd && cmd_q != CMD_IDLE |=> $stable(cmd_q))
    else $error("busy command replaced the running sequence");

endmodule

[bench/i2c_master_phase_sequencer_tb.sv]
// Self-checking testbench for the I2C master phase sequencer.
module i2c_master_phase_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmps_pkg::*;

  localparam int ShortTicks = 4;
  localparam int WriteTicks = 26;
  localparam int ReadTicks  = 20;
  localparam int StallLimit = 1000;
  localparam int RoundItems = 95;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] data_byte;
    logic             send_ack;
    logic             sda_in;
  } pin_item_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [OpW-1:0]    operation_i = OP_TICK;
  logic [ByteW-1:0]  data_byte_i = '0;
  logic              send_ack_i = 1'b0;
  logic              sda_in_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              scl_out_o;
  logic              sda_out_o;
  logic              busy_res_o;
  logic              done_res_o;
  logic [ByteW-1:0]  read_data_o;
  logic              acked_o;
  logic              error_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // bus model state
  logic              bus_enabled;
  logic [OpW-1:0]    bus_cmd;
  logic [PhaseW-1:0] bus_phase;
  logic [ByteW-1:0]  bus_shift;
  logic              bus_ack_sel;
  logic              bus_scl;
  logic              bus_sda;
  logic              bus_acked;

  pin_item_t pending_q[$];
  result_t   bus_expect_q[$];
  pin_item_t cur_item;
  logic      carrying = 1'b0;
  logic      calm = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        stall_cycles = 0;
  int        mismatches = 0;
  int        queued = 0;
  int        accepted = 0;
  int        results_seen = 0;
  int        writes_done = 0;
  int        reads_done = 0;
  int        frames_done = 0;
  int        rejected = 0;

  i2c_master_phase_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .send_ack_i  (send_ack_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .read_data_o (read_data_o),
    .acked_o     (acked_o),
    .error_o     (error_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic reset_bus_model();
    bus_enabled = 1'b0;
    bus_cmd     = CMD_IDLE;
    bus_phase   = '0;
    bus_shift   = '0;
    bus_ack_sel = 1'b0;
    bus_scl     = 1'b1;
    bus_sda     = 1'b1;
    bus_acked   = 1'b0;
  endtask

  // Apply one item to the bus model and queue the pin levels and flags it yields.
  task automatic predict_pins(input pin_item_t it);
    result_t        r;
    logic [OpW-1:0] ran;
    logic [SubW-1:0] sub;
    logic           last;
    logic           err;
    ran  = CMD_IDLE;
    last = 1'b0;
    err  = 1'b0;
    if (it.op >= OP_START && it.op <= OP_READ) begin
      if (!bus_enabled || bus_cmd != CMD_IDLE) begin
        err = 1'b1;
        rejected++;
      end else begin
        bus_cmd     = it.op;
        bus_phase   = '0;
        bus_acked   = 1'b0;
        bus_ack_sel = it.send_ack;
        bus_shift   = (it.op == OP_WRITE) ? it.data_byte : '0;
      end
    end else if (bus_cmd != CMD_IDLE) begin
      ran = bus_cmd;
      case (bus_cmd)
        OP_START: begin
          case (bus_phase)
            5'd0: bus_sda = 1'b1;
            5'd1: bus_scl = 1'b1;
            5'd2: bus_sda = 1'b0;
            default: begin
              bus_scl = 1'b0;
              last = 1'b1;
            end
          endcase
        end
        OP_STOP: begin
          case (bus_phase)
            5'd0: bus_scl = 1'b0;
            5'd1: bus_sda = 1'b0;
            5'd2: bus_scl = 1'b1;
            default: begin
              bus_sda = 1'b1;
              last = 1'b1;
            end
          endcase
        end
        OP_WRITE: begin
          if (bus_phase < PH_WR_ACK) begin
            sub = SubW'(bus_phase % 5'd3);
            if (sub == SUB_DATA) begin
              bus_sda   = bus_shift[ByteW-1];
              bus_shift = {bus_shift[ByteW-2:0], 1'b0};
            end else if (sub == SUB_HIGH) begin
              bus_scl = 1'b1;
            end else begin
              bus_scl = 1'b0;
            end
          end else if (bus_phase == PH_WR_ACK) begin
            // release SDA and sample the slave's ack
            bus_sda   = 1'b1;
            bus_scl   = 1'b1;
            bus_acked = !it.sda_in;
          end else begin
            bus_scl = 1'b0;
            last = 1'b1;
          end
        end
        OP_READ: begin
          if (bus_phase < PH_RD_ACK) begin
            if (!bus_phase[0]) begin
              bus_sda   = 1'b1;
              bus_scl   = 1'b1;
              bus_shift = {bus_shift[ByteW-2:0], it.sda_in};
            end else begin
              bus_scl = 1'b0;
            end
          end else if (bus_phase == PH_RD_ACK) begin
            bus_sda = !bus_ack_sel;
          end else if (bus_phase == PH_RD_SCL_HI) begin
            bus_scl = 1'b1;
          end else if (bus_phase == PH_RD_SCL_LO) begin
            bus_scl = 1'b0;
          end else begin
            bus_sda = 1'b1;
            last = 1'b1;
          end
        end
        default: ;
      endcase
      bus_phase = bus_phase + 1'b1;
      if (last) begin
        bus_cmd   = CMD_IDLE;
        bus_phase = '0;
        if (ran == OP_WRITE) writes_done++;
        else if (ran == OP_READ) reads_done++;
        else frames_done++;
      end
    end
    r.scl       = bus_scl;
    r.sda       = bus_sda;
    r.busy      = (bus_cmd != CMD_IDLE);
    r.done      = last;
    r.read_data = (last && ran == OP_READ) ? bus_shift : '0;
    r.acked     = last && ran == OP_WRITE && bus_acked;
    r.error     = err;
    bus_expect_q.push_back(r);
  endtask

  task automatic push_item(input logic [OpW-1:0] op, input logic [ByteW-1:0] data,
                           input logic sack, input logic sda);
    pin_item_t it;
    it.op        = op;
    it.data_byte = data;
    it.send_ack  = sack;
    it.sda_in    = sda;
    pending_q.push_back(it);
    queued++;
  endtask

  task automatic push_random(input logic [OpW-1:0] op);
    push_item(op, ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // Mostly plain ticks; the unused codes behave as ticks too.
  function automatic logic [OpW-1:0] tick_code();
    if ($urandom_range(0, 9) == 0) return OpW'($urandom_range(5, 7));
    return OP_TICK;
  endfunction

  function automatic int ticks_for(input logic [OpW-1:0] cmd);
    if (cmd == OP_WRITE) return WriteTicks;
    if (cmd == OP_READ) return ReadTicks;
    return ShortTicks;
  endfunction

  task automatic queue_transfer(input logic [OpW-1:0] cmd, input int ticks);
    logic [ByteW-1:0] data;
    case ($urandom_range(0, 7))
      0:       data = 8'h00;
      1:       data = 8'hFF;
      default: data = ByteW'($urandom_range(0, 255));
    endcase
    push_item(cmd, data, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat (ticks) push_random(tick_code());
  endtask

  task automatic queue_random_round(input int n);
    int first;
    int pick;
    logic [OpW-1:0] cmd;
    first = queued;
    while (queued - first < n) begin
      pick = $urandom_range(0, 99);
      cmd  = OpW'($urandom_range(OP_START, OP_READ));
      if (pick < 80) begin
        queue_transfer(cmd, ticks_for(cmd));
      end else if (pick < 90) begin
        // cut short: later commands hit a busy sequencer
        queue_transfer(cmd, $urandom_range(0, ticks_for(cmd) - 1));
      end else begin
        push_random(OpW'($urandom_range(0, 7)));
      end
    end
  endtask

  // Hold off until every queued item has been taken and answered.
  task automatic wait_drained();
    while (pending_q.size() != 0 || carrying || bus_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ENABLED, 2'b00};
    pwdata  <= {31'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    bus_enabled = value;
    if (bus_enabled && bus_cmd == CMD_IDLE) bus_scl = 1'b1;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_pins(cur_item);
        accepted++;
        carrying = 1'b0;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap == 0 && !calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 11);
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_item = pending_q.pop_front();
          carrying = 1'b1;
          operation_i <= cur_item.op;
          data_byte_i <= cur_item.data_byte;
          send_ack_i  <= cur_item.send_ack;
          sda_in_i    <= cur_item.sda_in;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (bus_expect_q.size() == 0) begin
          report_mismatch("result with no item waiting");
        end else begin
          want = bus_expect_q.pop_front();
          if (scl_out_o !== want.scl)
            report_mismatch($sformatf("result %0d scl_out: got %b, want %b",
                                      results_seen, scl_out_o, want.scl));
          if (sda_out_o !== want.sda)
            report_mismatch($sformatf("result %0d sda_out: got %b, want %b",
                                      results_seen, sda_out_o, want.sda));
          if (busy_res_o !== want.busy)
            report_mismatch($sformatf("result %0d busy: got %b, want %b",
                                      results_seen, busy_res_o, want.busy));
          if (done_res_o !== want.done)
            report_mismatch($sformatf("result %0d done: got %b, want %b",
                                      results_seen, done_res_o, want.done));
          if (read_data_o !== want.read_data)
            report_mismatch($sformatf("result %0d read_data: got %h, want %h",
                                      results_seen, read_data_o, want.read_data));
          if (acked_o !== want.acked)
            report_mismatch($sformatf("result %0d acked: got %b, want %b",
                                      results_seen, acked_o, want.acked));
          if (error_o !== want.error)
            report_mismatch($sformatf("result %0d error: got %b, want %b",
                                      results_seen, error_o, want.error));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pwrite && pready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Watchdog: no handshake for %0d cycles", StallLimit);
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    reset_bus_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // disabled: every command is refused, ticks and unused codes change nothing
    push_random(OP_START);
    push_random(OP_STOP);
    push_random(OP_WRITE);
    push_random(OP_READ);
    push_random(OP_TICK);
    push_random(3'd5);
    push_random(3'd6);
    push_random(3'd7);
    wait_drained();

    write_enable(1'b1);
    push_random(OP_START);
    push_random(OP_WRITE);
    repeat (ShortTicks) push_random(OP_TICK);
    push_random(OP_TICK);
    push_random(OP_STOP);
    push_random(OP_TICK);
    push_random(OP_TICK);
    push_random(3'd7);
    push_random(OP_TICK);
    push_item(OP_WRITE, 8'hFF, 1'b0, 1'b0);
    repeat (WriteTicks - 1) push_random(OP_TICK);
    push_item(OP_TICK, 8'h00, 1'b0, 1'b0);
    wait_drained();

    // drop enable partway through a read; the sequence must still run out
    push_item(OP_READ, 8'h00, 1'b1, 1'b1);
    repeat (8) push_random(OP_TICK);
    wait_drained();
    write_enable(1'b0);
    repeat (ReadTicks - 8) push_random(OP_TICK);
    push_random(OP_WRITE);
    push_random(OP_TICK);
    wait_drained();
    write_enable(1'b1);

    for (int round = 0; round < 6; round++) begin
      if (round == 5) calm = 1'b1;
      queue_random_round(RoundItems);
      wait_drained();
      if (round == 2) begin
        write_enable(1'b0);
        queue_random_round(30);
        wait_drained();
        write_enable(1'b1);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (bus_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", bus_expect_q.size()));
    $display("Run covered %0d items and %0d results: %0d bytes written, %0d bytes read,",
             accepted, results_seen, writes_done, reads_done);
    $display("  %0d start/stop frames, %0d commands refused, %0d mismatches",
             frames_done, rejected, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
